### hw/rtl/tds_tcc_pkg.sv
`timescale 1ns / 1ps

package tds_tcc_pkg;

	localparam int FRAC_BITS_DEF = 16;

	// field widths
	localparam int ADC_W       = 16;
	localparam int TEMP_W      = 12;
	localparam int GAIN_W      = 16;
	localparam int PPM_W       = 11;
	localparam int STATUS_W    = 2;
	localparam int DIGIT_W     = 6;
	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 40;

	localparam logic [GAIN_W-1:0] K_GAIN_RESET = 16'd256;

	// arithmetic constants
	localparam int ADC_FULL   = 65535;
	localparam int VOLT_SCALE = 5;
	localparam int COMP_NUM   = 500;
	localparam int D_OFFSET   = 250;
	localparam int DIVISOR_W  = 12;
	localparam int DIV_STEP   = 4;
	localparam int CV_INT_W   = 5;
	localparam int COEF3      = 13342;
	localparam int COEF2      = 25586;
	localparam int COEF1      = 85739;
	localparam int PPM_MAX    = 1400;
	localparam int DIV_BASE   = 51200;
	localparam int DIV_BASE_SHIFT = 11;

	// division by 25 and decimal digit extraction by reciprocal
	localparam int RECIP25        = 41944;
	localparam int RECIP25_SHIFT  = 20;
	localparam int RECIP100       = 41;
	localparam int RECIP100_SHIFT = 12;
	localparam int RECIP10        = 205;
	localparam int RECIP10_SHIFT  = 11;
	localparam int THOUSAND       = 1000;
	localparam int HUNDRED        = 100;
	localparam int TEN            = 10;
	localparam logic [DIGIT_W-1:0] ASCII_ZERO = 6'd48;

	typedef enum logic [STATUS_W-1:0] {
		CLAMP_NONE = 2'd0,
		CLAMP_ZERO = 2'd1,
		CLAMP_MAX  = 2'd2
	} clamp_t;

endpackage

### hw/rtl/tds_temperature_compensated_conversion_top.sv
`timescale 1ns / 1ps
// throughput: one item per cycle while m_axis_tready is high
// the restoring divider resolves 4 quotient bits per stage
// a stalled output holds its stage; earlier stages keep filling bubbles
// arst_n clears all stage valid bits and loads k_gain with 1.0 (256)
module tds_temperature_compensated_conversion_top #(
	parameter int FRAC_BITS = tds_tcc_pkg::FRAC_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// adc_code [15:0], temp_tenths [27:16], zero [31:28]
	input  logic [tds_tcc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// tds_ppm [10:0], clamp_status [12:11], digit_thousands [18:13],
	// digit_hundreds [24:19], digit_tens [30:25], digit_ones [36:31], zero [39:37]
	output logic [tds_tcc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [tds_tcc_pkg::GAIN_W-1:0]        cfg_data
);
	import tds_tcc_pkg::*;

	localparam int AW   = ADC_W + 3;
	localparam int PW   = AW + FRAC_BITS;
	localparam int VW   = FRAC_BITS + 3;
	localparam int SW   = FRAC_BITS + 5;
	localparam int NW   = FRAC_BITS + 12;
	localparam int CW   = FRAC_BITS + CV_INT_W;
	localparam int DS   = (CW + DIV_STEP - 1) / DIV_STEP;
	localparam int QB   = DS * DIV_STEP;
	localparam int DW   = DIVISOR_W;
	localparam int V2W  = FRAC_BITS + 10;
	localparam int V3W  = FRAC_BITS + 15;
	localparam int P2W  = FRAC_BITS + 25;
	localparam int P1W  = FRAC_BITS + 22;
	localparam int UW   = FRAC_BITS + 29;
	localparam int LOW  = (UW + 1) / 2;
	localparam int HIW  = UW - LOW;
	localparam int PRW  = UW + GAIN_W;
	localparam int XLSB = FRAC_BITS + DIV_BASE_SHIFT;
	localparam int NS   = 13 + DS;

	localparam int ST_S1 = 0;
	localparam int ST_S2 = 1;
	localparam int ST_S3 = 2;
	localparam int ST_SD = 3;
	localparam int ST_S4 = ST_SD + DS;
	localparam int ST_S5 = ST_S4 + 1;
	localparam int ST_S6 = ST_S4 + 2;
	localparam int ST_S7 = ST_S4 + 3;
	localparam int ST_S8 = ST_S4 + 4;
	localparam int ST_S9 = ST_S4 + 5;
	localparam int ST_S10 = ST_S4 + 6;
	localparam int ST_S11 = ST_S4 + 7;
	localparam int ST_S12 = ST_S4 + 8;
	localparam int ST_S13 = ST_S4 + 9;

	localparam logic [PRW-1:0] BOUND = PRW'(PPM_MAX * DIV_BASE) << FRAC_BITS;

	logic [GAIN_W-1:0] k_gain_q;
	logic [NS-1:0]     vld_q;
	logic [NS-1:0]     adv;

	// configuration
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_gain_q <= K_GAIN_RESET;
		end else if (cfg_valid) begin
			k_gain_q <= cfg_data;
		end
	end

	// stage advance and valid chain
	always_comb begin
		adv[NS-1] = !vld_q[NS-1] || m_axis_tready;
		for (int i = NS - 2; i >= 0; i--) begin
			adv[i] = !vld_q[i] || adv[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= s_axis_tvalid;
			end
			for (int i = 1; i < NS; i++) begin
				if (adv[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	assign s_axis_tready = adv[0];

	// s1: offset temperature, first fold of the divide by full scale
	logic [ADC_W-1:0]         adc;
	logic [TEMP_W-1:0]        temp;
	logic signed [DW:0]       d_val;
	logic [AW-1:0]            a5;
	logic [PW-1:0]            p_wide;
	logic [VW-1:0]            h_val;
	logic [SW-1:0]            s_val;
	clamp_t                   flg_in;
	logic [VW-1:0]            h_s1;
	logic [SW-1:0]            s_s1;
	logic [DW-1:0]            dv_s1;
	clamp_t                   flg_s1;

	always_comb begin
		adc    = s_axis_tdata[ADC_W-1:0];
		temp   = s_axis_tdata[ADC_W+TEMP_W-1:ADC_W];
		d_val  = signed'({temp[TEMP_W-1], temp}) + signed'((DW+1)'(D_OFFSET));
		a5     = AW'(adc) * AW'(VOLT_SCALE);
		p_wide = PW'(a5) << FRAC_BITS;
		h_val  = p_wide[PW-1:ADC_W];
		s_val  = SW'(h_val) + SW'(p_wide[ADC_W-1:0]);
		if (d_val == '0) begin
			flg_in = CLAMP_MAX;
		end else if (d_val[DW] || k_gain_q == '0) begin
			flg_in = CLAMP_ZERO;
		end else begin
			flg_in = CLAMP_NONE;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[ST_S1]) begin
			h_s1   <= h_val;
			s_s1   <= s_val;
			dv_s1  <= d_val[DW-1:0];
			flg_s1 <= flg_in;
		end
	end

	// s2: second fold gives the scaled voltage
	logic [SW-1:0] h2_val;
	logic [SW-1:0] s2_val;
	logic [VW-1:0] vq_val;
	logic [VW-1:0] vq_s2;
	logic [DW-1:0] dv_s2;
	clamp_t        flg_s2;

	always_comb begin
		h2_val = s_s1 >> ADC_W;
		s2_val = h2_val + SW'(s_s1[ADC_W-1:0]);
		vq_val = h_s1 + VW'(h2_val) + VW'(s2_val >= SW'(ADC_FULL));
	end

	always_ff @(posedge clk) begin
		if (adv[ST_S2]) begin
			vq_s2  <= vq_val;
			dv_s2  <= dv_s1;
			flg_s2 <= flg_s1;
		end
	end

	// s3: dividend of the compensation divide
	logic [NW-1:0] n_s3;
	logic [DW-1:0] dv_s3;
	clamp_t        flg_s3;

	always_ff @(posedge clk) begin
		if (adv[ST_S3]) begin
			n_s3   <= NW'(vq_s2) * NW'(COMP_NUM);
			dv_s3  <= dv_s2;
			flg_s3 <= flg_s2;
		end
	end

	// restoring divider, DIV_STEP quotient bits per stage
	logic [DW-1:0] rem_sd [DS];
	logic [QB-1:0] dvd_sd [DS];
	logic [QB-1:0] quo_sd [DS];
	logic [DW-1:0] dvs_sd [DS];
	clamp_t        flg_sd [DS];

	for (genvar j = 0; j < DS; j++) begin : g_div
		logic [DW-1:0] rem_in;
		logic [QB-1:0] dvd_in;
		logic [QB-1:0] quo_in;
		logic [DW-1:0] dvs_in;
		clamp_t        flg_j;
		logic [DW-1:0] rem_nx;
		logic [QB-1:0] dvd_nx;
		logic [QB-1:0] quo_nx;

		if (j == 0) begin : g_first
			logic over;
			assign over   = (DW+CW)'(n_s3) >= ((DW+CW)'(dv_s3) << CW);
			assign rem_in = DW'(n_s3[NW-1:QB]);
			assign dvd_in = n_s3[QB-1:0];
			assign quo_in = '0;
			assign dvs_in = dv_s3;
			assign flg_j  = (flg_s3 == CLAMP_NONE && over) ? CLAMP_MAX : flg_s3;
		end else begin : g_next
			assign rem_in = rem_sd[j-1];
			assign dvd_in = dvd_sd[j-1];
			assign quo_in = quo_sd[j-1];
			assign dvs_in = dvs_sd[j-1];
			assign flg_j  = flg_sd[j-1];
		end

		always_comb begin
			logic [DW:0] trial;
			rem_nx = rem_in;
			dvd_nx = dvd_in;
			quo_nx = quo_in;
			for (int i = 0; i < DIV_STEP; i++) begin
				trial  = {rem_nx, dvd_nx[QB-1]};
				dvd_nx = dvd_nx << 1;
				if (trial >= {1'b0, dvs_in}) begin
					rem_nx = DW'(trial - {1'b0, dvs_in});
					quo_nx = {quo_nx[QB-2:0], 1'b1};
				end else begin
					rem_nx = trial[DW-1:0];
					quo_nx = {quo_nx[QB-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv[ST_SD+j]) begin
				rem_sd[j] <= rem_nx;
				dvd_sd[j] <= dvd_nx;
				quo_sd[j] <= quo_nx;
				dvs_sd[j] <= dvs_in;
				flg_sd[j] <= flg_j;
			end
		end
	end

	// s4: square
	logic [CW-1:0]     cv;
	logic [2*CW-1:0]   sq;
	logic [V2W-1:0]    v2_s4;
	logic [CW-1:0]     cv_s4;
	clamp_t            flg_s4;

	always_comb begin
		cv = quo_sd[DS-1][CW-1:0];
		sq = (2*CW)'(cv) * (2*CW)'(cv);
	end

	always_ff @(posedge clk) begin
		if (adv[ST_S4]) begin
			v2_s4  <= sq[2*CW-1:FRAC_BITS];
			cv_s4  <= cv;
			flg_s4 <= flg_sd[DS-1];
		end
	end

	// s5: cube
	logic [V2W+CW-1:0] cube;
	logic [V3W-1:0]    v3_s5;
	logic [V2W-1:0]    v2_s5;
	logic [CW-1:0]     cv_s5;
	clamp_t            flg_s5;

	assign cube = (V2W+CW)'(v2_s4) * (V2W+CW)'(cv_s4);

	always_ff @(posedge clk) begin
		if (adv[ST_S5]) begin
			v3_s5  <= cube[V2W+CW-1:FRAC_BITS];
			v2_s5  <= v2_s4;
			cv_s5  <= cv_s4;
			flg_s5 <= flg_s4;
		end
	end

	// s6: polynomial terms
	logic [UW-1:0]  p3_s6;
	logic [P2W-1:0] p2_s6;
	logic [P1W-1:0] p1_s6;
	clamp_t         flg_s6;

	always_ff @(posedge clk) begin
		if (adv[ST_S6]) begin
			p3_s6  <= UW'(v3_s5) * UW'(COEF3);
			p2_s6  <= P2W'(v2_s5) * P2W'(COEF2);
			p1_s6  <= P1W'(cv_s5) * P1W'(COEF1);
			flg_s6 <= flg_s5;
		end
	end

	// s7: polynomial sum, sign check
	logic [UW:0]   num;
	logic [UW-1:0] num_s7;
	clamp_t        flg_s7;

	assign num = {1'b0, p3_s6} + (UW+1)'(p1_s6) - (UW+1)'(p2_s6);

	always_ff @(posedge clk) begin
		if (adv[ST_S7]) begin
			num_s7 <= num[UW-1:0];
			if (flg_s6 == CLAMP_NONE && (num[UW] || num == '0)) begin
				flg_s7 <= CLAMP_ZERO;
			end else begin
				flg_s7 <= flg_s6;
			end
		end
	end

	// s8: gain partial products
	logic [LOW+GAIN_W-1:0] pl_s8;
	logic [HIW+GAIN_W-1:0] ph_s8;
	clamp_t                flg_s8;

	always_ff @(posedge clk) begin
		if (adv[ST_S8]) begin
			pl_s8  <= (LOW+GAIN_W)'(num_s7[LOW-1:0]) * (LOW+GAIN_W)'(k_gain_q);
			ph_s8  <= (HIW+GAIN_W)'(num_s7[UW-1:LOW]) * (HIW+GAIN_W)'(k_gain_q);
			flg_s8 <= flg_s7;
		end
	end

	// s9: gain product
	logic [PRW-1:0] prod_s9;
	clamp_t         flg_s9;

	always_ff @(posedge clk) begin
		if (adv[ST_S9]) begin
			prod_s9 <= (PRW'(ph_s8) << LOW) + PRW'(pl_s8);
			flg_s9  <= flg_s8;
		end
	end

	// s10: upper bound check, divide by the remaining factor of 25
	logic [ADC_W-1:0]   xq;
	logic [2*ADC_W-1:0] qx;
	logic [PPM_W-1:0]   q_s10;
	clamp_t             flg_s10;

	always_comb begin
		xq = prod_s9[XLSB+ADC_W-1:XLSB];
		qx = (2*ADC_W)'(xq) * (2*ADC_W)'(RECIP25);
	end

	always_ff @(posedge clk) begin
		if (adv[ST_S10]) begin
			q_s10 <= qx[RECIP25_SHIFT+PPM_W-1:RECIP25_SHIFT];
			if (flg_s9 == CLAMP_NONE && prod_s9 > BOUND) begin
				flg_s10 <= CLAMP_MAX;
			end else begin
				flg_s10 <= flg_s9;
			end
		end
	end

	// s11: clamp select
	logic [PPM_W-1:0] ppm_s11;
	clamp_t           flg_s11;

	always_ff @(posedge clk) begin
		if (adv[ST_S11]) begin
			case (flg_s10)
				CLAMP_ZERO: ppm_s11 <= '0;
				CLAMP_MAX:  ppm_s11 <= PPM_W'(PPM_MAX);
				default:    ppm_s11 <= q_s10;
			endcase
			flg_s11 <= flg_s10;
		end
	end

	// s12: thousands and hundreds
	logic             th_val;
	logic [9:0]       r_val;
	logic [15:0]      hm;
	logic [3:0]       h_dig;
	logic [PPM_W-1:0] ppm_s12;
	clamp_t           flg_s12;
	logic             th_s12;
	logic [3:0]       h_s12;
	logic [6:0]       r2_s12;

	always_comb begin
		th_val = ppm_s11 >= PPM_W'(THOUSAND);
		r_val  = 10'(ppm_s11 - (th_val ? PPM_W'(THOUSAND) : '0));
		hm     = 16'(r_val) * 16'(RECIP100);
		h_dig  = hm[RECIP100_SHIFT+3:RECIP100_SHIFT];
	end

	always_ff @(posedge clk) begin
		if (adv[ST_S12]) begin
			ppm_s12 <= ppm_s11;
			flg_s12 <= flg_s11;
			th_s12  <= th_val;
			h_s12   <= h_dig;
			r2_s12  <= 7'(r_val - 10'(h_dig) * 10'(HUNDRED));
		end
	end

	// s13: tens and ones, output register
	logic [14:0]        tm;
	logic [3:0]         t_dig;
	logic [3:0]         o_dig;
	logic [PPM_W-1:0]   ppm_s13;
	clamp_t             flg_s13;
	logic [DIGIT_W-1:0] thou_s13;
	logic [DIGIT_W-1:0] hund_s13;
	logic [DIGIT_W-1:0] tens_s13;
	logic [DIGIT_W-1:0] ones_s13;

	always_comb begin
		tm    = 15'(r2_s12) * 15'(RECIP10);
		t_dig = tm[RECIP10_SHIFT+3:RECIP10_SHIFT];
		o_dig = 4'(r2_s12 - 7'(t_dig) * 7'(TEN));
	end

	always_ff @(posedge clk) begin
		if (adv[ST_S13]) begin
			ppm_s13  <= ppm_s12;
			flg_s13  <= flg_s12;
			thou_s13 <= ASCII_ZERO + DIGIT_W'(th_s12);
			hund_s13 <= ASCII_ZERO + DIGIT_W'(h_s12);
			tens_s13 <= ASCII_ZERO + DIGIT_W'(t_dig);
			ones_s13 <= ASCII_ZERO + DIGIT_W'(o_dig);
		end
	end

	assign m_axis_tvalid = vld_q[NS-1];
	assign m_axis_tdata  = {3'b000, ones_s13, tens_s13, hund_s13, thou_s13, flg_s13, ppm_s13};

endmodule

### hw/rtl/tds_tcc_checker.sv
`timescale 1ns / 1ps

module tds_tcc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_axis_tready,
	input logic                                m_axis_tvalid,
	input logic                                m_axis_tready,
	input logic [tds_tcc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import tds_tcc_pkg::*;

	logic [PPM_W-1:0]    ppm;
	logic [STATUS_W-1:0] status;
	logic [DIGIT_W-1:0]  thou;

	assign ppm    = m_axis_tdata[PPM_W-1:0];
	assign status = m_axis_tdata[PPM_W+STATUS_W-1:PPM_W];
	assign thou   = m_axis_tdata[PPM_W+STATUS_W+DIGIT_W-1:PPM_W+STATUS_W];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output transfer changed while stalled");

	a_max_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && status == STATUS_W'(CLAMP_MAX) |-> ppm == PPM_W'(PPM_MAX))
		else $error("upper clamp without full scale value");

	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && status == STATUS_W'(CLAMP_ZERO) |-> ppm == '0)
		else $error("lower clamp without zero value");

	a_thousands: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ppm <= PPM_W'(PPM_MAX)
			&& thou == ASCII_ZERO + DIGIT_W'(ppm >= PPM_W'(THOUSAND)))
		else $error("value out of range or thousands digit wrong");

	a_ready_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled while output empty");

endmodule

bind tds_temperature_compensated_conversion_top tds_tcc_checker u_tds_tcc_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

### dv/tb_tds_temperature_compensated_conversion_top.sv
`timescale 1ns / 1ps

module tb_tds_temperature_compensated_conversion_top;
	import tds_tcc_pkg::*;

	localparam int FRAC      = FRAC_BITS_DEF;
	localparam int HOLD_LEN  = 400;
	localparam int TAIL_WAIT = 40;

	typedef struct packed {
		logic [2:0]         pad;
		logic [DIGIT_W-1:0] ones;
		logic [DIGIT_W-1:0] tens;
		logic [DIGIT_W-1:0] hundreds;
		logic [DIGIT_W-1:0] thousands;
		clamp_t             status;
		logic [PPM_W-1:0]   ppm;
	} ppm_result_t;

	class ppm_scoreboard;
		ppm_result_t   pending_ppm[$];
		logic [GAIN_W-1:0] gain;
		int mismatches;
		int orphans;
		int checked;
		int samples;
		int status_seen[3];

		function new();
			gain = K_GAIN_RESET;
		endfunction

		function void set_gain(logic [GAIN_W-1:0] g);
			gain = g;
		endfunction

		function int pending_count();
			return pending_ppm.size();
		endfunction

		function int failures();
			return mismatches + orphans + pending_ppm.size();
		endfunction

		function ppm_result_t pack_ppm(longint ppm, clamp_t st);
			ppm_result_t r;
			r.pad       = '0;
			r.ppm       = PPM_W'(ppm);
			r.status    = st;
			r.thousands = ASCII_ZERO + DIGIT_W'(ppm / THOUSAND);
			r.hundreds  = ASCII_ZERO + DIGIT_W'(ppm % THOUSAND / HUNDRED);
			r.tens      = ASCII_ZERO + DIGIT_W'(ppm % HUNDRED / TEN);
			r.ones      = ASCII_ZERO + DIGIT_W'(ppm % TEN);
			return r;
		endfunction

		function ppm_result_t predict_ppm(logic [ADC_W-1:0] adc, logic [TEMP_W-1:0] temp);
			longint d, vq, cv, v2, v3, num, limit;
			d = longint'(D_OFFSET) + longint'($signed(temp));
			if (d == 0)
				return pack_ppm(PPM_MAX, CLAMP_MAX);
			if (d < 0 || gain == 0)
				return pack_ppm(0, CLAMP_ZERO);
			vq = ((longint'(adc) * VOLT_SCALE) <<< FRAC) / ADC_FULL;
			cv = (vq * COMP_NUM) / d;
			if (cv >= (longint'(32) <<< FRAC))
				return pack_ppm(PPM_MAX, CLAMP_MAX);
			v2  = (cv * cv) >>> FRAC;
			v3  = (v2 * cv) >>> FRAC;
			num = longint'(COEF3) * v3 - longint'(COEF2) * v2 + longint'(COEF1) * cv;
			if (num <= 0)
				return pack_ppm(0, CLAMP_ZERO);
			limit = ((longint'(PPM_MAX) * DIV_BASE) <<< FRAC) / longint'(gain);
			if (num > limit)
				return pack_ppm(PPM_MAX, CLAMP_MAX);
			return pack_ppm((num * longint'(gain)) / (longint'(DIV_BASE) <<< FRAC), CLAMP_NONE);
		endfunction

		function void note_sample(logic [ADC_W-1:0] adc, logic [TEMP_W-1:0] temp);
			pending_ppm.push_back(predict_ppm(adc, temp));
			samples++;
		endfunction

		function void check_result(logic [OUT_TDATA_W-1:0] data);
			ppm_result_t got, exp_r;
			got = ppm_result_t'(data);
			if (pending_ppm.size() == 0) begin
				orphans++;
				if (mismatches + orphans <= 10)
					$display("unexpected result transfer: tdata=%h", data);
				return;
			end
			exp_r = pending_ppm.pop_front();
			checked++;
			if (int'(exp_r.status) < 3)
				status_seen[int'(exp_r.status)]++;
			if (got.ppm !== exp_r.ppm || got.status !== exp_r.status
					|| got.thousands !== exp_r.thousands || got.hundreds !== exp_r.hundreds
					|| got.tens !== exp_r.tens || got.ones !== exp_r.ones
					|| got.pad !== exp_r.pad) begin
				mismatches++;
				if (mismatches + orphans <= 10)
					$display("mismatch #%0d: expected ppm=%0d status=%0d digits=%0d,%0d,%0d,%0d | got ppm=%0d status=%0d digits=%0d,%0d,%0d,%0d pad=%0d",
						checked, exp_r.ppm, exp_r.status, exp_r.thousands, exp_r.hundreds,
						exp_r.tens, exp_r.ones, got.ppm, got.status, got.thousands,
						got.hundreds, got.tens, got.ones, got.pad);
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [GAIN_W-1:0]      cfg_data;

	logic hold_off;
	int   send_idle_pct;
	int   recv_stall_pct;
	int   gain_settings;
	ppm_scoreboard sb;

	tds_temperature_compensated_conversion_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// result side: check each transfer, then pick next ready
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_result(m_axis_tdata);
		if (hold_off)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// long receiver hold-off, counted here
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off) begin
				repeat (HOLD_LEN) @(posedge clk);
				hold_off <= 1'b0;
			end
		end
	end

	task automatic send_sample(input logic [ADC_W-1:0] adc, input logic [TEMP_W-1:0] temp);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'b0, temp, adc};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_sample(adc, temp);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (sb.pending_count() != 0)
			@(posedge clk);
	endtask

	task automatic write_gain(input logic [GAIN_W-1:0] g);
		cfg_valid <= 1'b1;
		cfg_data  <= g;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.set_gain(g);
		gain_settings++;
	endtask

	task automatic send_random(input int count);
		logic [ADC_W-1:0]  adc;
		logic [TEMP_W-1:0] temp;
		int unsigned       r;
		repeat (count) begin
			r = $urandom_range(99);
			if (r < 10)
				temp = TEMP_W'($urandom_range(4095));
			else if (r < 15)
				temp = TEMP_W'(int'($urandom_range(10)) - 255);
			else
				temp = TEMP_W'(int'($urandom_range(1800)) - 550);
			r = $urandom_range(99);
			if (r < 3)
				adc = '0;
			else if (r < 6)
				adc = '1;
			else if (r < 10)
				adc = ADC_W'($urandom_range(1, 16));
			else if (r < 40)
				adc = ADC_W'($urandom_range(40000));
			else
				adc = ADC_W'($urandom_range(65535));
			send_sample(adc, temp);
		end
	endtask

	task automatic send_directed();
		logic [ADC_W-1:0]  adc_list[20];
		logic [TEMP_W-1:0] temp_list[20];
		adc_list  = '{16'd0, 16'd65535, 16'd1, 16'd65535, 16'd65535, 16'd0, 16'd0,
			16'd32768, 16'd0, 16'd1000, 16'd40000, 16'd40000, 16'd65535, 16'd30000,
			16'd20000, 16'd50000, 16'd12345, 16'd2, 16'd21845, 16'd43690};
		temp_list = '{12'd250, 12'd250, 12'd250, -12'sd550, 12'd1250, -12'sd550, 12'd1250,
			-12'sd250, -12'sd250, -12'sd251, 12'h800, 12'h7FF, -12'sd240, 12'd250,
			12'd0, 12'd1250, 12'd500, 12'd250, 12'hFFF, 12'h555};
		foreach (adc_list[i])
			send_sample(adc_list[i], temp_list[i]);
	endtask

	initial begin
		arst_n         = 1'b0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		m_axis_tready  = 1'b0;
		cfg_valid      = 1'b0;
		cfg_data       = '0;
		hold_off       = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		gain_settings  = 0;
		sb = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset gain, corner samples
		send_directed();
		drain_results();

		write_gain(16'd0);
		send_directed();
		drain_results();

		write_gain(16'hFFFF);
		send_directed();
		send_random(280);
		drain_results();

		send_idle_pct = 54;
		write_gain(K_GAIN_RESET);
		send_random(300);
		drain_results();

		send_idle_pct  = 0;
		recv_stall_pct = 54;
		write_gain(16'd1);
		send_random(200);
		drain_results();

		send_idle_pct  = 34;
		recv_stall_pct = 34;
		write_gain(GAIN_W'($urandom_range(65535)));
		send_random(250);
		drain_results();

		// fill the pipeline against a stopped receiver
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		write_gain(16'd512);
		hold_off <= 1'b1;
		send_random(80);
		drain_results();

		send_idle_pct  = 34;
		recv_stall_pct = 34;
		write_gain(GAIN_W'($urandom_range(128, 1024)));
		send_random(300);
		drain_results();

		repeat (TAIL_WAIT) @(posedge clk);

		$display("%0d samples sent over %0d gain settings, %0d results checked",
			sb.samples, gain_settings, sb.checked);
		$display("in range %0d, clamped low %0d, clamped high %0d; %0d mismatches, %0d unexpected",
			sb.status_seen[0], sb.status_seen[1], sb.status_seen[2], sb.mismatches, sb.orphans);
		if (sb.failures() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### sim.f
hw/rtl/tds_tcc_pkg.sv
hw/rtl/tds_temperature_compensated_conversion_top.sv
hw/rtl/tds_tcc_checker.sv
dv/tb_tds_temperature_compensated_conversion_top.sv
